### src/assert_macros.svh
// assertion macros shared by the rtl of the link quality monitor
// no dependencies; simulation builds get the checks, synthesis gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RLQM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("rlqm assertion failed");
`define RLQM_ASSERT_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);
`else
`define RLQM_ASSERT(label, clk, rst_n, prop)
`define RLQM_ASSERT_MSG(label, clk, rst_n, prop, msg)
`endif
`endif

### src/rlqm_pkg.sv
// shared types and constants of the radio link quality monitor
// no dependencies; used by radio_link_quality_monitor_core
package rlqm_pkg;

    localparam int MAX_RETRIES = 15;
    localparam int COUNT_WIDTH = 32;

    localparam int SEQ_W      = 8;
    localparam int RETRY_W    = 4;
    localparam int MEAN_W     = 4;
    localparam int QUALITY_W  = 7;
    localparam int TOTAL_W    = 32;
    localparam int RUN_W      = 8;
    localparam int SUM_W      = 36;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = SUM_W / DIGIT_W;
    localparam int NUM_PASSES = MEAN_W + 1;
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);
    localparam int PASS_CNT_W  = $clog2(NUM_PASSES);
    localparam int MEAN_LEVELS = 2 ** MEAN_W;
    localparam int PERCENT_FULL = 100;

    localparam logic [7:0] PREAMBLE_OK = 8'h7E;
    localparam logic [7:0] CONNECT_LIMIT_RESET = 8'd4;

    localparam logic [1:0] TX_DELIVERED = 2'd0;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_TWO_WAY_MODE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CONNECT_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]         tx_status;
        logic [RETRY_W-1:0] retry_count;
        logic               response_seen;
        logic [7:0]         response_preamble;
        logic [7:0]         response_sequence;
    } t_in_item;

    typedef struct packed {
        logic [SEQ_W-1:0]     sequence_used;
        logic                 exchange_ok;
        logic                 connected;
        logic [RETRY_W-1:0]   last_retries;
        logic [MEAN_W-1:0]    mean_retries;
        logic [QUALITY_W-1:0] quality_percent;
        logic [TOTAL_W-1:0]   sent_total;
        logic [TOTAL_W-1:0]   lost_total;
        logic [TOTAL_W-1:0]   answered_total;
    } t_out_item;

    // quality for each clamped mean: 100 - ceil(mean * 100 / max), floored at 0
    function automatic logic [MEAN_LEVELS*QUALITY_W-1:0] build_quality_table();
        logic [MEAN_LEVELS*QUALITY_W-1:0] tbl;
        int ceilv;
        tbl = '0;
        for (int m = 0; m < MEAN_LEVELS; m++) begin
            ceilv = (m * PERCENT_FULL + MAX_RETRIES - 1) / MAX_RETRIES;
            tbl[m*QUALITY_W +: QUALITY_W] = (ceilv >= PERCENT_FULL) ? '0 :
                                            QUALITY_W'(PERCENT_FULL - ceilv);
        end
        return tbl;
    endfunction

    localparam logic [MEAN_LEVELS*QUALITY_W-1:0] QUALITY_TABLE = build_quality_table();

endpackage

### src/radio_link_quality_monitor_core.sv
// radio link quality monitor: counters, response check, link hysteresis and
// a digit-serial restoring divider for the mean retry count; uses rlqm_pkg
// and assert_macros.svh
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// a request first updates the counters, then runs the divider (5 quotient
// trials of 9 four-bit digits each) and last loads the output register.
// a new request is taken while a finished result still waits in the output
// register; a stalled output holds the divider result until taken.
// reset is synchronous, active low; config is always ready.

`include "assert_macros.svh"

module radio_link_quality_monitor_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  rlqm_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output rlqm_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rlqm_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [rlqm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic                                 r_two_way, n_two_way;
    logic [7:0]                           r_limit, n_limit;
    logic [rlqm_pkg::SEQ_W-1:0]           r_seq, n_seq;
    logic [rlqm_pkg::COUNT_WIDTH-1:0]     r_sent, n_sent;
    logic [rlqm_pkg::COUNT_WIDTH-1:0]     r_lost, n_lost;
    logic [rlqm_pkg::COUNT_WIDTH-1:0]     r_answered, n_answered;
    logic [rlqm_pkg::SUM_W-1:0]           r_sum, n_sum;
    logic [rlqm_pkg::RUN_W-1:0]           r_succ_run, n_succ_run;
    logic [rlqm_pkg::RUN_W-1:0]           r_fail_run, n_fail_run;
    logic                                 r_link_up, n_link_up;

    logic [rlqm_pkg::SUM_W-1:0]           r_rem, n_rem;
    logic [rlqm_pkg::SUM_W-1:0]           r_div, n_div;
    logic [rlqm_pkg::SUM_W-1:0]           r_diff, n_diff;
    logic                                 r_borrow, n_borrow;
    logic [rlqm_pkg::NUM_PASSES-1:0]      r_quo, n_quo;
    logic [rlqm_pkg::DIGIT_CNT_W-1:0]     r_digit, n_digit;
    logic [rlqm_pkg::PASS_CNT_W-1:0]      r_pass, n_pass;

    rlqm_pkg::t_out_item                  r_res, n_res;
    rlqm_pkg::t_out_item                  r_out, n_out;
    logic                                 r_out_valid, n_out_valid;

    logic                                 in_fire;
    logic [rlqm_pkg::SEQ_W-1:0]           seq_next;
    logic [rlqm_pkg::COUNT_WIDTH-1:0]     sent_inc;
    logic                                 sent_wrap;
    logic                                 delivered;
    logic                                 resp_ok;
    logic                                 exch_ok;
    logic [rlqm_pkg::RUN_W-1:0]           succ_inc;
    logic [rlqm_pkg::RUN_W-1:0]           fail_inc;
    logic [rlqm_pkg::DIGIT_W:0]           digit_sub;
    logic [rlqm_pkg::MEAN_W-1:0]          mean_val;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_fire   = i_in_valid && o_in_ready;
    assign seq_next  = r_seq + 1'b1;
    assign sent_inc  = r_sent + 1'b1;
    assign sent_wrap = (sent_inc == '0);
    assign delivered = (i_in_data.tx_status == rlqm_pkg::TX_DELIVERED);
    assign resp_ok   = i_in_data.response_seen &&
                       (i_in_data.response_preamble == rlqm_pkg::PREAMBLE_OK) &&
                       (i_in_data.response_sequence == seq_next);
    assign exch_ok   = delivered && (!r_two_way || resp_ok);
    assign succ_inc  = r_succ_run + 1'b1;
    assign fail_inc  = r_fail_run + 1'b1;

    // one digit of the trial subtraction, borrow carried between cycles
    assign digit_sub = {1'b0, r_rem[rlqm_pkg::DIGIT_W-1:0]}
                     - {1'b0, r_div[rlqm_pkg::DIGIT_W-1:0]}
                     - (rlqm_pkg::DIGIT_W+1)'(r_borrow);

    // top quotient bit set means the quotient reached 16: clamp
    assign mean_val = r_quo[rlqm_pkg::MEAN_W] ? '1 : r_quo[rlqm_pkg::MEAN_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_two_way   = r_two_way;
        n_limit     = r_limit;
        n_seq       = r_seq;
        n_sent      = r_sent;
        n_lost      = r_lost;
        n_answered  = r_answered;
        n_sum       = r_sum;
        n_succ_run  = r_succ_run;
        n_fail_run  = r_fail_run;
        n_link_up   = r_link_up;
        n_rem       = r_rem;
        n_div       = r_div;
        n_diff      = r_diff;
        n_borrow    = r_borrow;
        n_quo       = r_quo;
        n_digit     = r_digit;
        n_pass      = r_pass;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                rlqm_pkg::REG_TWO_WAY_MODE:  n_two_way = i_cfg_data[0];
                rlqm_pkg::REG_CONNECT_LIMIT: n_limit   = i_cfg_data;
                default: ;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_seq = seq_next;
                    if (sent_wrap) begin
                        n_sent = rlqm_pkg::COUNT_WIDTH'(1);
                        n_sum  = rlqm_pkg::SUM_W'(i_in_data.retry_count);
                    end else begin
                        n_sent = sent_inc;
                        if (i_in_data.retry_count <= rlqm_pkg::RETRY_W'(rlqm_pkg::MAX_RETRIES)) begin
                            n_sum = r_sum + rlqm_pkg::SUM_W'(i_in_data.retry_count);
                        end
                    end
                    if (!delivered) begin
                        n_lost = r_lost + 1'b1;
                    end
                    if (delivered && r_two_way && resp_ok) begin
                        n_answered = r_answered + 1'b1;
                    end
                    // hysteresis on the connected flag
                    if (exch_ok) begin
                        n_fail_run = '0;
                        if (!r_link_up) begin
                            if (succ_inc > r_limit) begin
                                n_succ_run = '0;
                                n_link_up  = 1'b1;
                            end else begin
                                n_succ_run = succ_inc;
                            end
                        end
                    end else begin
                        n_succ_run = '0;
                        if (fail_inc > r_limit) begin
                            n_fail_run = '0;
                            n_link_up  = 1'b0;
                        end else begin
                            n_fail_run = fail_inc;
                        end
                    end

                    n_res.sequence_used   = seq_next;
                    n_res.exchange_ok     = exch_ok;
                    n_res.connected       = n_link_up;
                    n_res.last_retries    = i_in_data.retry_count;
                    n_res.mean_retries    = '0;
                    n_res.quality_percent = '0;
                    n_res.sent_total      = rlqm_pkg::TOTAL_W'(n_sent);
                    n_res.lost_total      = rlqm_pkg::TOTAL_W'(n_lost);
                    n_res.answered_total  = rlqm_pkg::TOTAL_W'(n_answered);

                    // divisor starts at sent << 4 for the overflow trial
                    n_rem    = n_sum;
                    n_div    = rlqm_pkg::SUM_W'({n_sent, {rlqm_pkg::MEAN_W{1'b0}}});
                    n_borrow = 1'b0;
                    n_quo    = '0;
                    n_digit  = '0;
                    n_pass   = '0;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                n_rem    = {r_rem[rlqm_pkg::DIGIT_W-1:0],
                            r_rem[rlqm_pkg::SUM_W-1:rlqm_pkg::DIGIT_W]};
                n_div    = {r_div[rlqm_pkg::DIGIT_W-1:0],
                            r_div[rlqm_pkg::SUM_W-1:rlqm_pkg::DIGIT_W]};
                n_diff   = {digit_sub[rlqm_pkg::DIGIT_W-1:0],
                            r_diff[rlqm_pkg::SUM_W-1:rlqm_pkg::DIGIT_W]};
                n_borrow = digit_sub[rlqm_pkg::DIGIT_W];
                n_digit  = r_digit + 1'b1;
                if (r_digit == rlqm_pkg::DIGIT_CNT_W'(rlqm_pkg::NUM_DIGITS - 1)) begin
                    // end of a trial: both rings are back in place
                    n_digit  = '0;
                    n_borrow = 1'b0;
                    n_quo    = {r_quo[rlqm_pkg::NUM_PASSES-2:0], ~digit_sub[rlqm_pkg::DIGIT_W]};
                    if (!digit_sub[rlqm_pkg::DIGIT_W]) begin
                        n_rem = n_diff;
                    end
                    n_div = n_div >> 1;
                    if (r_pass == rlqm_pkg::PASS_CNT_W'(rlqm_pkg::NUM_PASSES - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_pass = r_pass + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out                 = r_res;
                    n_out.mean_retries    = mean_val;
                    n_out.quality_percent =
                        rlqm_pkg::QUALITY_TABLE[mean_val*rlqm_pkg::QUALITY_W +: rlqm_pkg::QUALITY_W];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_two_way   <= 1'b1;
            r_limit     <= rlqm_pkg::CONNECT_LIMIT_RESET;
            r_seq       <= '0;
            r_sent      <= '0;
            r_lost      <= '0;
            r_answered  <= '0;
            r_sum       <= '0;
            r_succ_run  <= '0;
            r_fail_run  <= '0;
            r_link_up   <= 1'b0;
            r_borrow    <= 1'b0;
            r_quo       <= '0;
            r_digit     <= '0;
            r_pass      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_two_way   <= n_two_way;
            r_limit     <= n_limit;
            r_seq       <= n_seq;
            r_sent      <= n_sent;
            r_lost      <= n_lost;
            r_answered  <= n_answered;
            r_sum       <= n_sum;
            r_succ_run  <= n_succ_run;
            r_fail_run  <= n_fail_run;
            r_link_up   <= n_link_up;
            r_borrow    <= n_borrow;
            r_quo       <= n_quo;
            r_digit     <= n_digit;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_diff <= n_diff;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    `RLQM_ASSERT_MSG(a_accept_starts_div, i_clk, i_rst_n, in_fire |=> (r_state == S_DIV), "accepted request did not start the divider")
    `RLQM_ASSERT_MSG(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_DONE), "output loaded outside the done state")
    `RLQM_ASSERT(a_quality_range, i_clk, i_rst_n, r_out_valid |-> (r_out.quality_percent <= rlqm_pkg::QUALITY_W'(rlqm_pkg::PERCENT_FULL)))
    `RLQM_ASSERT(a_div_counters, i_clk, i_rst_n, (r_state == S_DIV) |-> ((r_digit < rlqm_pkg::DIGIT_CNT_W'(rlqm_pkg::NUM_DIGITS)) && (r_pass < rlqm_pkg::PASS_CNT_W'(rlqm_pkg::NUM_PASSES))))

endmodule
